@@ src/qvb_pkg.sv @@
// Package for the quad vertex batcher: sizes, codes, coefficients and item types.
// Used by the channel interfaces and by quad_vertex_batcher_top.
package qvb_pkg;

  localparam int SLOT_COUNT    = 32;
  localparam int QUAD_CAPACITY = 8192;

  localparam int SLOT_IW = $clog2(SLOT_COUNT);
  localparam int SLOT_CW = $clog2(SLOT_COUNT + 1);
  localparam int QC_W    = $clog2(QUAD_CAPACITY + 1);

  localparam logic [16:0] COEF_A = 17'd102944;
  localparam logic [16:0] COEF_B = 17'd42048;
  localparam logic [16:0] COEF_C = 17'd4640;

  localparam logic [1:0] OP_BEGIN    = 2'd0;
  localparam logic [1:0] OP_SOLID    = 2'd1;
  localparam logic [1:0] OP_TEXTURED = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_SLOTS_FULL = 2'd1;
  localparam logic [1:0] ST_QUADS_FULL = 2'd2;

  localparam logic [31:0] WHITE_RGBA  = 32'hFFFF_FFFF;
  localparam logic [15:0] UNIT_TILING = 16'h0100;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [15:0]        angle;
    logic [31:0]        rgba;
    logic [15:0]        texture_id;
    logic [15:0]        tiling;
  } qvb_in_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0]        vert_color;
    logic               tex_u;
    logic               tex_v;
    logic [4:0]         slot;
    logic [15:0]        vert_tiling;
    logic [15:0]        index_total;
    logic [1:0]         status;
    logic               last;
  } qvb_out_t;

endpackage

@@ src/qvb_in_if.sv @@
// Valid/ready channel that carries one quad request item.
// Depends on qvb_pkg for the payload type.
interface qvb_in_if;
  logic              valid;
  logic              ready;
  qvb_pkg::qvb_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/qvb_out_if.sv @@
// Valid/ready channel that carries one vertex or error item.
// Depends on qvb_pkg for the payload type.
interface qvb_out_if;
  logic              valid;
  logic              ready;
  qvb_pkg::qvb_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/quad_vertex_batcher_top.sv @@
// Quad vertex batcher: turns quad requests into four vertices with texture slot batching.
// Depends on qvb_pkg, qvb_in_if and qvb_out_if.
//
// One item is taken at a time. A quad runs through one shared 33x18 signed multiplier
// under a step sequencer: eight steps evaluate the sine and cosine polynomials and four
// more form the scaled corner products, then each vertex is formed in S_CORNER and
// S_FINAL and handed over in S_OUTW, where it waits for the sink to take it.
// A textured quad first scans the slot table in S_CHK and S_CMP, entry by entry, and
// adds the id when it is new and the table has room, before that work starts.
// Begin-scene and unused codes return to idle with no output; an error gives one item.
module quad_vertex_batcher_top (
  input  logic      clk,
  input  logic      rst_n,
  qvb_in_if.sink    in_ch,
  qvb_out_if.source out_ch
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHK    = 8'b0000_0010,
    S_CMP    = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_CORNER = 8'b0001_0000,
    S_FINAL  = 8'b0010_0000,
    S_OUTW   = 8'b0100_0000,
    S_SPARE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [qvb_pkg::SLOT_CW-1:0] slots_used_r;
  logic [qvb_pkg::QC_W-1:0]    quad_count_r;
  logic [qvb_pkg::SLOT_CW-1:0] idx_r;
  logic [qvb_pkg::SLOT_IW-1:0] slot_r;
  logic [3:0]                  step_r;
  logic [1:0]                  k_r;
  logic                        out_valid_r;
  qvb_pkg::qvb_in_t            item_r;
  qvb_pkg::qvb_out_t           out_r;
  qvb_pkg::qvb_out_t           err_item;

  logic [15:0] slot_mem [qvb_pkg::SLOT_COUNT];
  logic [15:0] rd_r;

  logic [16:0] x2_r, s_r, s0_r, c0_r;
  logic signed [50:0] a1_r, a2_r, b1_r, b2_r;
  logic signed [51:0] dx_r, dy_r;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod;
  logic [16:0] xq, xa, prod_hi;
  logic signed [17:0] s0s, c0s, sn, cs;
  logic signed [51:0] a1e, a2e, b1e, b2e;
  logic signed [34:0] rx, ry;
  logic signed [35:0] sum_x, sum_y;
  logic [31:0] vx, vy;
  logic [15:0] index_now;
  logic in_acc, out_acc, quads_full;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign out_acc    = out_ch.valid && out_ch.ready;
  assign quads_full = quad_count_r >= qvb_pkg::QC_W'(qvb_pkg::QUAD_CAPACITY);
  assign index_now  = 16'({quad_count_r, 2'b00}) + 16'({quad_count_r, 1'b0});

  assign in_ch.ready  = state_r == S_IDLE;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    err_item             = '0;
    err_item.index_total = index_now;
    err_item.status      = (state_r == S_IDLE) ? qvb_pkg::ST_QUADS_FULL : qvb_pkg::ST_SLOTS_FULL;
    err_item.last        = 1'b1;
  end

  // Shared multiplier and its operand selection.
  assign xq  = {1'b0, item_r.angle[13:0], 2'b00};
  assign xa  = step_r[2] ? 17'd65536 - xq : xq;
  assign s0s = $signed({1'b0, s0_r});
  assign c0s = $signed({1'b0, c0_r});

  always_comb begin
    unique case (item_r.angle[15:14])
      2'd0: begin sn = s0s;  cs = c0s;  end
      2'd1: begin sn = c0s;  cs = -s0s; end
      2'd2: begin sn = -s0s; cs = -c0s; end
      default: begin sn = -c0s; cs = s0s; end
    endcase
  end

  always_comb begin
    if (step_r[3]) begin
      case (step_r[1:0])
        2'd0:    begin mul_a = 33'(item_r.size_x); mul_b = cs; end
        2'd1:    begin mul_a = 33'(item_r.size_y); mul_b = sn; end
        2'd2:    begin mul_a = 33'(item_r.size_x); mul_b = sn; end
        default: begin mul_a = 33'(item_r.size_y); mul_b = cs; end
      endcase
    end else begin
      case (step_r[1:0])
        2'd0:    begin mul_a = $signed({16'd0, xa});           mul_b = $signed({1'b0, xa}); end
        2'd1:    begin mul_a = $signed({16'd0, qvb_pkg::COEF_C}); mul_b = $signed({1'b0, x2_r}); end
        2'd2:    begin mul_a = $signed({16'd0, s_r});          mul_b = $signed({1'b0, x2_r}); end
        default: begin mul_a = $signed({16'd0, s_r});          mul_b = $signed({1'b0, xa}); end
      endcase
    end
  end

  assign prod    = mul_a * mul_b;
  assign prod_hi = prod[32:16];

  // Corner combination, rounding and saturation.
  assign a1e = 52'(a1_r);
  assign a2e = 52'(a2_r);
  assign b1e = 52'(b1_r);
  assign b2e = 52'(b2_r);

  logic ux_neg, uy_neg;
  assign ux_neg = ~(k_r[0] ^ k_r[1]);
  assign uy_neg = ~k_r[1];

  logic signed [51:0] dx_w, dy_w, rxw, ryw;
  assign dx_w = (ux_neg ? -a1e : a1e) - (uy_neg ? -a2e : a2e);
  assign dy_w = (ux_neg ? -b1e : b1e) + (uy_neg ? -b2e : b2e);
  assign rxw  = (dx_r + 52'sd65536) >>> 17;
  assign ryw  = (dy_r + 52'sd65536) >>> 17;
  assign rx   = rxw[34:0];
  assign ry   = ryw[34:0];
  assign sum_x = 36'(item_r.pos_x) + 36'(rx);
  assign sum_y = 36'(item_r.pos_y) + 36'(ry);

  always_comb begin
    if (sum_x[35:31] == 5'b00000 || sum_x[35:31] == 5'b11111) vx = sum_x[31:0];
    else vx = sum_x[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (sum_y[35:31] == 5'b00000 || sum_y[35:31] == 5'b11111) vy = sum_y[31:0];
    else vy = sum_y[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.data.op == qvb_pkg::OP_SOLID || in_ch.data.op == qvb_pkg::OP_TEXTURED) begin
            if (quads_full) state_nxt = S_OUTW;
            else if (in_ch.data.op == qvb_pkg::OP_TEXTURED) state_nxt = S_CHK;
            else state_nxt = S_MUL;
          end
        end
      end
      S_CHK: begin
        if (idx_r >= slots_used_r) begin
          if (slots_used_r >= qvb_pkg::SLOT_CW'(qvb_pkg::SLOT_COUNT)) state_nxt = S_OUTW;
          else state_nxt = S_MUL;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP:    state_nxt = (rd_r == item_r.texture_id) ? S_MUL : S_CHK;
      S_MUL:    state_nxt = (step_r == 4'd11) ? S_CORNER : S_MUL;
      S_CORNER: state_nxt = S_FINAL;
      S_FINAL:  state_nxt = S_OUTW;
      S_OUTW: begin
        if (out_acc) state_nxt = out_r.last ? S_IDLE : S_CORNER;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slots_used_r <= qvb_pkg::SLOT_CW'(1);
      quad_count_r <= '0;
      out_valid_r  <= 1'b0;
      step_r       <= '0;
      k_r          <= '0;
      idx_r        <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            step_r <= '0;
            k_r    <= '0;
            idx_r  <= qvb_pkg::SLOT_CW'(1);
            if (in_ch.data.op == qvb_pkg::OP_BEGIN) begin
              quad_count_r <= '0;
              slots_used_r <= qvb_pkg::SLOT_CW'(1);
            end else if (in_ch.data.op == qvb_pkg::OP_SOLID ||
                         in_ch.data.op == qvb_pkg::OP_TEXTURED) begin
              if (quads_full) out_valid_r <= 1'b1;
              else if (in_ch.data.op == qvb_pkg::OP_SOLID) quad_count_r <= quad_count_r + 1'b1;
            end
          end
        end
        S_CHK: begin
          if (idx_r >= slots_used_r) begin
            if (slots_used_r >= qvb_pkg::SLOT_CW'(qvb_pkg::SLOT_COUNT)) begin
              out_valid_r <= 1'b1;
            end else begin
              slots_used_r <= slots_used_r + 1'b1;
              quad_count_r <= quad_count_r + 1'b1;
            end
          end
        end
        S_CMP: begin
          if (rd_r == item_r.texture_id) quad_count_r <= quad_count_r + 1'b1;
          else idx_r <= idx_r + 1'b1;
        end
        S_MUL:   step_r <= step_r + 1'b1;
        S_FINAL: out_valid_r <= 1'b1;
        S_OUTW: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            k_r         <= k_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Slot table.
  always_ff @(posedge clk) begin
    if (state_r == S_CHK) begin
      if (idx_r >= slots_used_r) begin
        if (slots_used_r < qvb_pkg::SLOT_CW'(qvb_pkg::SLOT_COUNT))
          slot_mem[slots_used_r[qvb_pkg::SLOT_IW-1:0]] <= item_r.texture_id;
      end else begin
        rd_r <= slot_mem[idx_r[qvb_pkg::SLOT_IW-1:0]];
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_ch.data;
      slot_r <= '0;
      if (quads_full) out_r <= err_item;
    end
    if (state_r == S_CHK && idx_r >= slots_used_r) begin
      slot_r <= slots_used_r[qvb_pkg::SLOT_IW-1:0];
      if (slots_used_r >= qvb_pkg::SLOT_CW'(qvb_pkg::SLOT_COUNT)) out_r <= err_item;
    end
    if (state_r == S_CMP) slot_r <= idx_r[qvb_pkg::SLOT_IW-1:0];
    if (state_r == S_MUL) begin
      if (step_r[3]) begin
        case (step_r[1:0])
          2'd0:    a1_r <= prod;
          2'd1:    a2_r <= prod;
          2'd2:    b1_r <= prod;
          default: b2_r <= prod;
        endcase
      end else begin
        case (step_r[1:0])
          2'd0: x2_r <= prod_hi;
          2'd1: s_r  <= qvb_pkg::COEF_B - prod_hi;
          2'd2: s_r  <= qvb_pkg::COEF_A - prod_hi;
          default: begin
            if (step_r[2]) c0_r <= prod_hi;
            else s0_r <= prod_hi;
          end
        endcase
      end
    end
    if (state_r == S_CORNER) begin
      dx_r <= dx_w;
      dy_r <= dy_w;
    end
    if (state_r == S_FINAL) begin
      out_r.vert_x      <= vx;
      out_r.vert_y      <= vy;
      out_r.vert_z      <= item_r.pos_z;
      out_r.tex_u       <= k_r[0] ^ k_r[1];
      out_r.tex_v       <= k_r[1];
      out_r.slot        <= 5'(slot_r);
      out_r.index_total <= index_now;
      out_r.status      <= qvb_pkg::ST_OK;
      out_r.last        <= k_r == 2'd3;
      if (item_r.op == qvb_pkg::OP_TEXTURED) begin
        out_r.vert_color  <= qvb_pkg::WHITE_RGBA;
        out_r.vert_tiling <= item_r.tiling;
      end else begin
        out_r.vert_color  <= item_r.rgba;
        out_r.vert_tiling <= qvb_pkg::UNIT_TILING;
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while an item is still offered");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.status != qvb_pkg::ST_OK |-> out_ch.data.last)
    else $error("error item not marked last");

  a_slots_range: assert property (@(posedge clk) disable iff (!rst_n)
    slots_used_r != '0 && slots_used_r <= qvb_pkg::SLOT_CW'(qvb_pkg::SLOT_COUNT))
    else $error("slot fill count out of range");

  a_quad_range: assert property (@(posedge clk) disable iff (!rst_n)
    quad_count_r <= qvb_pkg::QC_W'(qvb_pkg::QUAD_CAPACITY))
    else $error("quad count beyond capacity");

endmodule
